// ----- hw/rtl/tkrct_pkg.sv -----
// Shared types and constants for the ranked counter table.
// No dependencies; imported by tkrct_store and top_k_ranked_counter_table_top.
`default_nettype none

package tkrct_pkg;

    localparam int TKRCT_CAPACITY = 64;
    localparam int KEY_W          = 32;
    localparam int CNT_W          = 32;
    localparam int RANK_W         = 7;
    localparam int REQ_W          = 3;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INCR       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_GET_LOWEST = 3'd2;
    localparam logic [REQ_W-1:0] REQ_GET_KTH    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  amount;
        logic [RANK_W-1:0] rank_k;
    } tkrct_req_t;

    typedef struct packed {
        logic             ok;
        logic [KEY_W-1:0] result_key;
        logic [CNT_W-1:0] result_count;
    } tkrct_rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } tkrct_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_RISE_RD,
        ST_RISE_CMP,
        ST_QRY_RD,
        ST_QRY_DATA,
        ST_RESP
    } tkrct_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tkrct_store.sv -----
// Entry storage: one write port, one read port with registered read data.
// Depends on tkrct_pkg for the entry type.
`default_nettype none

module tkrct_store
    import tkrct_pkg::*;
#(
    parameter int DEPTH  = TKRCT_CAPACITY,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire tkrct_entry_t       wr_data,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    output tkrct_entry_t            rd_data
);

    tkrct_entry_t mem [DEPTH];
    tkrct_entry_t rd_data_reg;

    // Write one entry per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/top_k_ranked_counter_table_top.sv -----
// Ranked counter table: (key, count) entries kept sorted by count, slot 0 highest.
// A request searches the slots from slot 0 for its key, reading and comparing one slot at a time;
// an increment that hits, or an insert of an absent key, then moves the entry up slot by slot
// while its count exceeds the one above. Queries read one slot (none when empty or rank invalid).
// One item at a time through one memory read port; a finished result waits in the output
// register while the next item is accepted. Reset empties the table at once.
`default_nettype none

module top_k_ranked_counter_table_top
    import tkrct_pkg::*;
#(
    parameter int CAPACITY = TKRCT_CAPACITY
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire tkrct_req_t s_req,
    output logic      m_valid,
    input  wire logic m_ready,
    output tkrct_rsp_t m_rsp
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (FILL_W > RANK_W) ? FILL_W : RANK_W;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CAPACITY);
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(CAPACITY - 1);

    tkrct_state_t      state_reg, state_next;
    tkrct_req_t        req_reg, req_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    tkrct_entry_t      mv_reg, mv_next;
    tkrct_rsp_t        rsp_reg, rsp_next;
    logic              m_valid_reg, m_valid_next;
    tkrct_rsp_t        m_rsp_reg, m_rsp_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    tkrct_entry_t      wr_data;
    logic [IDX_W-1:0]  rd_addr;
    tkrct_entry_t      rd_data;

    logic              s_fire;
    logic              k_valid;
    logic              fill_empty;
    logic              fill_full;
    logic              scan_end;
    logic              key_hit;
    logic              moves_up;
    logic              out_free;
    logic [CMP_W-1:0]  k_ext;
    logic [CMP_W-1:0]  k_m1;
    logic [FILL_W-1:0] fill_m1;
    logic [CNT_W:0]    sum_wide;
    logic [CNT_W-1:0]  sum_sat;

    tkrct_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared conditions
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign k_ext      = CMP_W'(s_req.rank_k);
    assign k_valid    = (k_ext != '0) && (k_ext <= CMP_W'(fill_reg));
    assign k_m1       = CMP_W'(req_reg.rank_k) - 1'b1;
    assign fill_m1    = fill_reg - 1'b1;
    assign fill_empty = (fill_reg == '0);
    assign fill_full  = (fill_reg == FILL_MAX);
    assign scan_end   = (scan_reg == fill_reg);
    assign key_hit    = (rd_data.key == req_reg.key);
    assign moves_up   = (rd_data.count < mv_reg.count);
    assign out_free   = !m_valid_reg || m_ready;
    assign sum_wide   = {1'b0, rd_data.count} + {1'b0, req_reg.amount};
    assign sum_sat    = sum_wide[CNT_W] ? '1 : sum_wide[CNT_W-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_req.req_type)
                        REQ_INCR, REQ_INSERT: state_next = ST_SCAN_RD;
                        REQ_GET_LOWEST:
                            state_next = fill_empty ? ST_RESP : ST_QRY_RD;
                        REQ_GET_KTH:
                            state_next = k_valid ? ST_QRY_RD : ST_RESP;
                        default: state_next = ST_RESP;
                    endcase
                end
            end
            ST_SCAN_RD: begin
                if (!scan_end) begin
                    state_next = ST_SCAN_CMP;
                end else if (req_reg.req_type == REQ_INSERT) begin
                    state_next = ST_RISE_RD;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_SCAN_CMP: begin
                if (!key_hit) begin
                    state_next = ST_SCAN_RD;
                end else if (req_reg.req_type == REQ_INCR) begin
                    state_next = ST_RISE_RD;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_RISE_RD:  state_next = (pos_reg == '0) ? ST_RESP : ST_RISE_CMP;
            ST_RISE_CMP: state_next = moves_up ? ST_RISE_RD : ST_RESP;
            ST_QRY_RD:   state_next = ST_QRY_DATA;
            ST_QRY_DATA: state_next = ST_RESP;
            ST_RESP:     state_next = out_free ? ST_IDLE : ST_RESP;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        req_next     = req_reg;
        fill_next    = fill_reg;
        scan_next    = scan_reg;
        pos_next     = pos_reg;
        mv_next      = mv_reg;
        rsp_next     = rsp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rsp_next   = m_rsp_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = mv_reg;
        rd_addr      = scan_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    req_next  = s_req;
                    scan_next = '0;
                    rsp_next  = '0;
                    if (s_req.req_type == REQ_CLEAR) begin
                        fill_next   = '0;
                        rsp_next.ok = 1'b1;
                    end
                end
            end
            ST_SCAN_RD: begin
                rd_addr = scan_reg[IDX_W-1:0];
                // Key absent: place a new entry at the end of the table
                if (scan_end && req_reg.req_type == REQ_INSERT) begin
                    mv_next.key   = req_reg.key;
                    mv_next.count = req_reg.amount;
                    if (fill_full) begin
                        pos_next = IDX_LAST;
                    end else begin
                        pos_next  = fill_reg[IDX_W-1:0];
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            ST_SCAN_CMP: begin
                if (!key_hit) begin
                    scan_next = scan_reg + 1'b1;
                end else if (req_reg.req_type == REQ_INCR) begin
                    mv_next.key   = req_reg.key;
                    mv_next.count = sum_sat;
                    pos_next      = scan_reg[IDX_W-1:0];
                end
            end
            ST_RISE_RD: begin
                rd_addr = pos_reg - 1'b1;
                // Top reached: drop the moving entry into slot 0
                if (pos_reg == '0) begin
                    wr_en       = 1'b1;
                    rsp_next.ok = 1'b1;
                end
            end
            ST_RISE_CMP: begin
                wr_en = 1'b1;
                if (moves_up) begin
                    wr_data  = rd_data;
                    pos_next = pos_reg - 1'b1;
                end else begin
                    rsp_next.ok = 1'b1;
                end
            end
            ST_QRY_RD: begin
                if (req_reg.req_type == REQ_GET_KTH) begin
                    rd_addr = k_m1[IDX_W-1:0];
                end else begin
                    rd_addr = fill_m1[IDX_W-1:0];
                end
            end
            ST_QRY_DATA: begin
                rsp_next.ok           = 1'b1;
                rsp_next.result_count = rd_data.count;
                if (req_reg.req_type == REQ_GET_KTH) begin
                    rsp_next.result_key = rd_data.key;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rsp_next   = rsp_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        scan_reg  <= scan_next;
        pos_reg   <= pos_next;
        mv_reg    <= mv_next;
        rsp_reg   <= rsp_next;
        m_rsp_reg <= m_rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    // Table never holds more than its capacity
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("fill level beyond capacity");

    // Every accepted item takes the controller out of idle in the cycle after it is accepted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg != ST_IDLE)
        else $error("accepted item did not start");

    // Clear empties the table on the next cycle
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_req.req_type == REQ_CLEAR |=> fill_reg == '0)
        else $error("clear did not empty the table");

    // Memory writes happen only while reordering
    a_write_window: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_RISE_RD || state_reg == ST_RISE_CMP))
        else $error("entry write outside reorder");

    // Search compares only valid slots
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN_CMP |-> scan_reg < fill_reg)
        else $error("search past fill level");

endmodule

`default_nettype wire
